>>> rtl/laiir_pkg.sv
// Shared types, constants and register map of the lookahead second-order IIR filter.
// Used by every module of the filter; depends on nothing else.
package laiir_pkg;

    // Field and datapath widths.
    localparam int COEF_WIDTH     = 12;
    localparam int DATA_WIDTH     = 32;
    localparam int NUM_TAPS       = 3;
    localparam int NUM_REGS       = 7;
    localparam int REG_IDX_WIDTH  = 3;
    localparam int APB_ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;
    localparam int STEP_WIDTH     = 3;

    // Defaults for the top-level parameters.
    localparam int SAMPLE_WIDTH_DEF  = 12;
    localparam int PRODUCT_SHIFT_DEF = 16;

    // Fixed scaling of the feedback sum and of the output.
    localparam int FEEDBACK_SHIFT = 5;
    localparam int OUTPUT_SHIFT   = 5;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic [REG_IDX_WIDTH-1:0]     reg_idx_t;

    // Register map indexes.
    localparam reg_idx_t REG_GAIN_CURRENT  = 3'd0;
    localparam reg_idx_t REG_FORWARD_TAP0  = 3'd1;
    localparam reg_idx_t REG_FORWARD_TAP1  = 3'd2;
    localparam reg_idx_t REG_FORWARD_TAP2  = 3'd3;
    localparam reg_idx_t REG_FEEDBACK_TAP0 = 3'd4;
    localparam reg_idx_t REG_FEEDBACK_TAP1 = 3'd5;
    localparam reg_idx_t REG_FEEDBACK_TAP2 = 3'd6;
    localparam reg_idx_t REG_LAST          = REG_FEEDBACK_TAP2;

    // Coefficient values after reset, in register map order.
    localparam coef_t COEF_RESET [NUM_REGS] = '{
        12'sd423, 12'sd1002, 12'sd735, 12'sd156, 12'sd0, -12'sd122, -12'sd149
    };

    // Control of the shared multiply-accumulate unit for one cycle.
    typedef struct packed {
        logic clear;       // zero both sums
        logic load;        // capture a new product
        logic accumulate;  // add the captured product to a sum in the cycle after it is captured
        logic to_feedback; // target the feedback sum, else the feed-forward sum
    } mac_ctrl_t;

endpackage

>>> rtl/laiir_regs.sv
// APB coefficient register file of the lookahead second-order IIR filter.
// Depends on laiir_pkg for the register map and reset values.
module laiir_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [laiir_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [laiir_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [laiir_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready,
    output laiir_pkg::coef_t                    coef [laiir_pkg::NUM_REGS]
);

    laiir_pkg::coef_t    coef_reg [laiir_pkg::NUM_REGS];
    laiir_pkg::reg_idx_t reg_idx;
    logic                wr_en;

    // Registers sit on 32-bit word addresses.
    assign reg_idx = paddr[laiir_pkg::APB_ADDR_WIDTH-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Coefficient storage; writes beyond the last register are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < laiir_pkg::NUM_REGS; i++) begin
                coef_reg[i] <= laiir_pkg::COEF_RESET[i];
            end
        end else if (wr_en && reg_idx <= laiir_pkg::REG_LAST) begin
            coef_reg[reg_idx] <= pwdata[laiir_pkg::COEF_WIDTH-1:0];
        end
    end

    // Read data is the sign-extended coefficient.
    always_comb begin
        prdata = '0;
        if (reg_idx <= laiir_pkg::REG_LAST) begin
            prdata = laiir_pkg::APB_DATA_WIDTH'(coef_reg[reg_idx]);
        end
    end

    assign coef = coef_reg;

endmodule

>>> rtl/laiir_mac.sv
// Shared multiply, shift and accumulate unit of the lookahead second-order IIR filter.
// Depends on laiir_pkg for word types and the control struct.
module laiir_mac #(
    parameter int PRODUCT_SHIFT = laiir_pkg::PRODUCT_SHIFT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  laiir_pkg::mac_ctrl_t ctrl,
    input  laiir_pkg::word_t     mul_a,
    input  laiir_pkg::coef_t     mul_b,
    output laiir_pkg::word_t     scaled,
    output laiir_pkg::word_t     fb_sum,
    output laiir_pkg::word_t     ff_sum
);

    localparam int FULL_WIDTH = laiir_pkg::DATA_WIDTH + laiir_pkg::COEF_WIDTH;

    logic signed [FULL_WIDTH-1:0] prod_full;
    laiir_pkg::word_t             prod_reg;
    laiir_pkg::word_t             fb_sum_reg;
    laiir_pkg::word_t             ff_sum_reg;
    logic                         acc_en_reg;
    logic                         acc_fb_reg;

    // Full signed product; only the low word is kept, as 32-bit wrapping does.
    assign prod_full = FULL_WIDTH'(mul_a) * FULL_WIDTH'(mul_b);

    // Scaled term of the captured product.
    assign scaled = prod_reg >>> PRODUCT_SHIFT;

    // Product register.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            prod_reg <= prod_full[laiir_pkg::DATA_WIDTH-1:0];
        end
    end

    // Accumulate the scaled product in the cycle after it was captured.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
            acc_fb_reg <= 1'b0;
            fb_sum_reg <= '0;
            ff_sum_reg <= '0;
        end else begin
            acc_en_reg <= ctrl.load && ctrl.accumulate;
            acc_fb_reg <= ctrl.to_feedback;
            if (ctrl.clear) begin
                fb_sum_reg <= '0;
                ff_sum_reg <= '0;
            end else if (acc_en_reg) begin
                if (acc_fb_reg) begin
                    fb_sum_reg <= fb_sum_reg + scaled;
                end else begin
                    ff_sum_reg <= ff_sum_reg + scaled;
                end
            end
        end
    end

    assign fb_sum = fb_sum_reg;
    assign ff_sum = ff_sum_reg;

endmodule

>>> rtl/lookahead_iir_second_order.sv
// Top level of the lookahead second-order IIR filter: sequencer, delay line, ports.
// Depends on laiir_pkg, laiir_regs and laiir_mac.
//
//   Channel   Direction  Payload
//   s_*       in         s_tdata: sample_in (SAMPLE_WIDTH bits, signed), zero padded
//   m_*       out        m_tdata: sample_out (32 bits, signed)
//   APB       in/out     seven 12-bit signed coefficients at byte addresses 0x00..0x18
//
// Each sample passes through the states in order: an idle state that accepts the beat,
// then seven steps in which the single 32x12 multiplier forms the three feedback, three
// feed-forward and the gain product in turn, then an output state that forms the output beat.
// Reset clears the delay line and restores the coefficient reset values.
// A stalled output holds its beat; the next sample is accepted meanwhile and only
// its final step waits for the output register to free up.
module lookahead_iir_second_order #(
    parameter int SAMPLE_WIDTH  = laiir_pkg::SAMPLE_WIDTH_DEF,
    parameter int PRODUCT_SHIFT = laiir_pkg::PRODUCT_SHIFT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // sample_in in bits [SAMPLE_WIDTH-1:0]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,
    // sample_out in bits [31:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [laiir_pkg::DATA_WIDTH-1:0]     m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [laiir_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [laiir_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [laiir_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                 pready
);

    localparam logic [laiir_pkg::STEP_WIDTH-1:0] STEP_FF_FIRST = 3'd3;
    localparam logic [laiir_pkg::STEP_WIDTH-1:0] STEP_FORM_W   = 3'd4;
    localparam logic [laiir_pkg::STEP_WIDTH-1:0] STEP_GAIN     = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    state_t                              state_reg;
    logic [laiir_pkg::STEP_WIDTH-1:0]    step_reg;
    logic signed [SAMPLE_WIDTH-1:0]      x_reg;
    laiir_pkg::word_t                    w_reg;
    laiir_pkg::word_t                    delay_reg [laiir_pkg::NUM_TAPS];
    logic                                m_valid_reg;
    laiir_pkg::word_t                    m_data_reg;

    laiir_pkg::coef_t                    coef [laiir_pkg::NUM_REGS];
    laiir_pkg::mac_ctrl_t                mac_ctrl;
    laiir_pkg::word_t                    mul_a;
    laiir_pkg::coef_t                    mul_b;
    laiir_pkg::word_t                    scaled;
    laiir_pkg::word_t                    fb_sum;
    laiir_pkg::word_t                    ff_sum;
    logic [1:0]                          tap_idx;
    logic                                is_feedback;
    logic                                in_beat;
    logic                                out_free;
    laiir_pkg::word_t                    y_sum;

    laiir_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    laiir_mac #(
        .PRODUCT_SHIFT (PRODUCT_SHIFT)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .scaled  (scaled),
        .fb_sum  (fb_sum),
        .ff_sum  (ff_sum)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Steps 0..2 are feedback terms, 3..5 feed-forward terms, 6 the gain term.
    assign is_feedback = (step_reg < STEP_FF_FIRST);
    assign tap_idx     = is_feedback ? step_reg[1:0] : 2'(step_reg - STEP_FF_FIRST);

    // Operand selection for the shared multiplier.
    always_comb begin
        if (step_reg == STEP_GAIN) begin
            mul_a = w_reg;
            mul_b = coef[laiir_pkg::REG_GAIN_CURRENT];
        end else if (is_feedback) begin
            mul_a = delay_reg[tap_idx];
            mul_b = coef[laiir_pkg::REG_FEEDBACK_TAP0 + laiir_pkg::reg_idx_t'(tap_idx)];
        end else begin
            mul_a = delay_reg[tap_idx];
            mul_b = coef[laiir_pkg::REG_FORWARD_TAP0 + laiir_pkg::reg_idx_t'(tap_idx)];
        end
    end

    // Sums are cleared on the input beat; the gain product is not accumulated.
    always_comb begin
        mac_ctrl.clear       = in_beat;
        mac_ctrl.load        = (state_reg == ST_RUN);
        mac_ctrl.accumulate  = (step_reg != STEP_GAIN);
        mac_ctrl.to_feedback = is_feedback;
    end

    assign y_sum = scaled + ff_sum;

    // Sequencer, intermediate value, delay line and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < laiir_pkg::NUM_TAPS; i++) begin
                delay_reg[i] <= '0;
            end
        end else begin
            // The output register fills when a result forms and empties on its beat.
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        x_reg     <= s_tdata[SAMPLE_WIDTH-1:0];
                        step_reg  <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    // The feedback sum is complete by the time step 4 runs.
                    if (step_reg == STEP_FORM_W) begin
                        w_reg <= laiir_pkg::DATA_WIDTH'(x_reg)
                                 + (fb_sum <<< laiir_pkg::FEEDBACK_SHIFT);
                    end
                    if (step_reg == STEP_GAIN) begin
                        state_reg <= ST_OUT;
                    end else begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_data_reg   <= y_sum <<< laiir_pkg::OUTPUT_SHIFT;
                        delay_reg[2] <= delay_reg[1];
                        delay_reg[1] <= delay_reg[0];
                        delay_reg[0] <= w_reg;
                        step_reg     <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the lookahead second-order IIR filter: samples stream in,
// filtered samples stream out, and each output beat is checked against a bit-exact predictor.
// Depends on laiir_pkg and lookahead_iir_second_order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import laiir_pkg::*;

    localparam int SW       = SAMPLE_WIDTH_DEF;
    localparam int TDATA_W  = ((SW + 7) / 8) * 8;
    localparam int SETTLE   = 30;   // cycles that cover one sample through the block
    localparam int HOLD_LEN = 400;  // long receiver hold-off, in cycles
    localparam int OUT_OF_MAP = NUM_REGS;  // first index past the register map

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [TDATA_W-1:0]         s_tdata = '0;  // sample_in in [SW-1:0], zero padded
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [DATA_WIDTH-1:0]      m_tdata;       // sample_out in [31:0]
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_WIDTH-1:0]  paddr = '0;
    logic [APB_DATA_WIDTH-1:0]  pwdata = '0;
    logic [APB_DATA_WIDTH-1:0]  prdata;
    logic                       pready;

    // Samples waiting to be sent and filter outputs waiting to arrive.
    logic [SW-1:0] pending_samples [$];
    word_t         expected_outputs [$];

    // Filter state as the testbench sees it.
    coef_t coef_mirror [NUM_REGS] = COEF_RESET;
    word_t w_history [NUM_TAPS] = '{default: '0};

    int failures = 0;
    int hold_token = 0;

    lookahead_iir_second_order u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // A stored value times a coefficient, wrapped to 32 bits, then scaled down.
    function automatic word_t scale_product(word_t a, coef_t c);
        word_t p;
        p = a * word_t'(c);
        return p >>> PRODUCT_SHIFT_DEF;
    endfunction

    // One filter step: updates the delay line and returns the output sample.
    function automatic word_t filter_step(logic signed [SW-1:0] x);
        word_t fb;
        word_t ff;
        word_t w;
        word_t y;
        fb = '0;
        ff = '0;
        for (int i = 0; i < NUM_TAPS; i++) begin
            fb += scale_product(w_history[i], coef_mirror[REG_FEEDBACK_TAP0 + i]);
            ff += scale_product(w_history[i], coef_mirror[REG_FORWARD_TAP0 + i]);
        end
        w = word_t'(x) + (fb << FEEDBACK_SHIFT);
        y = scale_product(w, coef_mirror[REG_GAIN_CURRENT]) + ff;
        for (int i = NUM_TAPS - 1; i > 0; i--)
            w_history[i] = w_history[i - 1];
        w_history[0] = w;
        return y << OUTPUT_SHIFT;
    endfunction

    function automatic void report_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    // Sample driver: bursts of beats separated by random gaps.
    always @(posedge aclk) begin : drive_samples
        bit held;
        bit offer;
        int gap_left;
        int burst_left;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            gap_left = 0;
            burst_left = 0;
        end else begin
            held = s_tvalid;
            offer = 1'b0;
            if (s_tvalid && s_tready) begin
                expected_outputs.push_back(filter_step(s_tdata[SW-1:0]));
                void'(pending_samples.pop_front());
                held = 1'b0;
            end
            if (!held) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_samples.size() > 0) begin
                    offer = 1'b1;
                    s_tdata <= TDATA_W'(pending_samples[0]);
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            s_tvalid <= held | offer;
        end
    end

    // Result collector: checks each beat and stalls on a pattern of its own.
    always @(posedge aclk) begin : collect_results
        bit rdy;
        int hold_seen;
        int hold_left;
        int pattern_left;
        int stall_mode;
        int stall_phase;
        word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
            pattern_left = 0;
            stall_phase = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_outputs.size() == 0) begin
                    report_failure($sformatf("unexpected output beat 0x%08h", m_tdata));
                end else begin
                    want = expected_outputs.pop_front();
                    if (m_tdata !== want)
                        report_failure($sformatf(
                            "sample_out mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                            want, want, $signed(m_tdata), m_tdata));
                end
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    pattern_left = $urandom_range(16, 80);
                end
                pattern_left--;
                stall_phase++;
                case (stall_mode)
                    0: begin
                        rdy = 1'b1;
                    end
                    1: begin
                        rdy = (stall_phase % 3) == 0;
                    end
                    2: begin
                        rdy = 1'($urandom_range(0, 1));
                    end
                    default: begin
                        rdy = (stall_phase % 8) < 5;
                    end
                endcase
            end
            m_tready <= rdy;
        end
    end

    // Register write over APB; the mirror follows at the access edge.
    task automatic write_coef(int idx, logic [COEF_WIDTH-1:0] value);
        logic [APB_DATA_WIDTH-1:0] upper;
        upper = ($urandom_range(0, 1) == 1) ? $urandom : '0;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_WIDTH'(idx * 4);
        pwdata <= (upper & ~APB_DATA_WIDTH'(12'hFFF)) | APB_DATA_WIDTH'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx < NUM_REGS)
            coef_mirror[idx] = coef_t'(value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait until every queued sample has gone out and every result has come back.
    task automatic drain();
        do @(posedge aclk);
        while (pending_samples.size() != 0 || expected_outputs.size() != 0 || s_tvalid);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [SW-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 12'h7FF;
            1: return 12'h800;
            2: return SW'($signed($urandom_range(0, 31)) - 16);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_WIDTH-1:0] random_coef();
        case ($urandom_range(0, 7))
            0: return 12'h800;
            1: return 12'h7FF;
            2: return '0;
            3: return COEF_WIDTH'($signed($urandom_range(0, 127)) - 64);
            default: return COEF_WIDTH'($urandom);
        endcase
    endfunction

    // Stimulus: directed phases at the extremes, then random coefficient sets.
    initial begin : stimulus
        logic [SW-1:0] warmup [];
        logic [SW-1:0] all_low [];
        logic [SW-1:0] runaway [];
        warmup = {12'h000, 12'h001, 12'hFFF, 12'h7FF, 12'h800,
                  12'hAAA, 12'h555, 12'h000, 12'h000};
        all_low = {12'h7FF, 12'h7FF, 12'h800, 12'h800, 12'h7FF, 12'h000};
        runaway = {12'h800, 12'h800, 12'h800, 12'h800,
                   12'h7FF, 12'h7FF, 12'h7FF};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset coefficients, impulse and extremes.
        @(negedge aclk);
        foreach (warmup[i]) pending_samples.push_back(warmup[i]);
        drain();

        // Every coefficient at its most negative value, plus an ignored write past the map.
        for (int r = 0; r < NUM_REGS; r++)
            write_coef(r, 12'h800);
        write_coef(OUT_OF_MAP, COEF_WIDTH'($urandom));
        @(negedge aclk);
        foreach (all_low[i]) pending_samples.push_back(all_low[i]);
        drain();

        // Strong positive feedback and gain so the intermediate values wrap.
        write_coef(REG_GAIN_CURRENT, 12'h7FF);
        for (int r = REG_FEEDBACK_TAP0; r <= REG_FEEDBACK_TAP2; r++)
            write_coef(r, 12'h7FF);
        @(negedge aclk);
        foreach (runaway[i]) pending_samples.push_back(runaway[i]);
        drain();

        // Random phases, each with a partly rewritten coefficient set (the first phase rewrites all).
        for (int phase = 0; phase < 10; phase++) begin
            for (int r = 0; r < NUM_REGS; r++)
                if (phase == 0 || $urandom_range(0, 1) == 1)
                    write_coef(r, random_coef());
            if ($urandom_range(0, 3) == 0)
                write_coef(OUT_OF_MAP, COEF_WIDTH'($urandom));
            @(negedge aclk);
            for (int i = 0; i < 65; i++)
                pending_samples.push_back(random_sample());
            // Long receiver hold-off while the sender keeps offering beats.
            if (phase == 3) begin
                repeat (20) @(posedge aclk);
                hold_token <= hold_token + 1;
            end
            drain();
        end

        repeat (SETTLE) @(posedge aclk);
        if (failures == 0 && expected_outputs.size() == 0)
            $display("** lookahead_iir_second_order: PASSED **");
        else
            $display("** lookahead_iir_second_order: FAILED **");
        $finish;
    end

    // Run limit.
    initial begin : watchdog
        #2_000_000ns;
        $display("** lookahead_iir_second_order: FAILED **");
        $finish;
    end

endmodule
